>>> src/appliance_key_panel_fsm_top_assert.svh
// assertion macros shared by the key panel rtl
`ifndef APPLIANCE_KEY_PANEL_FSM_TOP_ASSERT_SVH
`define APPLIANCE_KEY_PANEL_FSM_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expression holds at every edge out of reset
`define AKP_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("key panel assertion failed");

// consequent holds in the cycle after the antecedent
`define AKP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key panel assertion failed");

`else

`define AKP_ASSERT_ALWAYS(label, clk, rst, expr)
`define AKP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/akp_pkg.sv
`timescale 1ns / 1ps

package akp_pkg;

   // key codes
   localparam logic [2:0] KEY_FAN    = 3'd1;
   localparam logic [2:0] KEY_LOCK   = 3'd2;
   localparam logic [2:0] KEY_TIMER  = 3'd3;
   localparam logic [2:0] KEY_FILTER = 3'd4;
   localparam logic [2:0] KEY_POWER  = 3'd5;
   localparam logic [2:0] KEY_TEST   = 3'd6;

   // beep codes
   localparam logic [1:0] BEEP_NONE  = 2'd0;
   localparam logic [1:0] BEEP_SHORT = 2'd1;
   localparam logic [1:0] BEEP_OPEN  = 2'd2;
   localparam logic [1:0] BEEP_CLOSE = 2'd3;

   // level limits
   localparam logic [2:0] LEVEL_MAX  = 3'd4;
   localparam logic [2:0] LEVEL_WRAP = 3'd5;
   localparam logic [2:0] LEVEL_OFF  = 3'd0;
   localparam logic [2:0] LEVEL_LOW  = 3'd1;

   typedef struct packed {
      logic [2:0] key_code;
      logic       short_press;
      logic       hold_3s;
      logic       hold_5s;
      logic       filter_due;
      logic       remote_ok;
      logic       reset_armed;
   } akp_req_type;

   typedef struct packed {
      logic       power_ind;
      logic [2:0] fan_led;
      logic [2:0] timer_led;
      logic       lock_ind;
      logic       display_off;
      logic       test_mode_out;
      logic [1:0] beep;
      logic       filter_clear;
      logic       remote_clear;
      logic       counters_clear;
      logic       lock_pending_out;
      logic       reset_pending_out;
   } akp_rsp_type;

   typedef struct packed {
      logic       power_state;
      logic [2:0] fan_level;
      logic [2:0] timer_level;
      logic [2:0] saved_fan;
      logic [2:0] saved_timer;
      logic       lock_state;
      logic       lock_pending;
      logic       reset_pending;
      logic       display_mark;
      logic       test_mode;
   } akp_state_type;

endpackage

>>> src/akp_if.sv
`timescale 1ns / 1ps

// key event channel
interface akp_req_if;
   import akp_pkg::*;
   logic        valid;
   logic        ready;
   akp_req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// panel result channel
interface akp_rsp_if;
   import akp_pkg::*;
   logic        valid;
   logic        ready;
   akp_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/akp_step.sv
`timescale 1ns / 1ps

module akp_step (
   input  akp_pkg::akp_state_type cur_state,
   input  akp_pkg::akp_req_type   req_data,
   output akp_pkg::akp_state_type nxt_state,
   output akp_pkg::akp_rsp_type   rsp_data
);
   import akp_pkg::*;

   logic [1:0] beep;
   logic       fclr;
   logic       rclr;
   logic       cclr;
   logic [2:0] lvl_inc;
   logic       any_press;
   logic       sp;
   logic       h3;
   logic       h5;

   assign sp        = req_data.short_press;
   assign h3        = req_data.hold_3s;
   assign h5        = req_data.hold_5s;
   assign any_press = sp | h3 | h5;

   // next state and pulses for one key beat
   always_comb begin
      nxt_state = cur_state;
      beep      = BEEP_NONE;
      fclr      = 1'b0;
      rclr      = 1'b0;
      cclr      = 1'b0;
      lvl_inc   = 3'd0;
      if (any_press) begin
         if (req_data.key_code == KEY_POWER && !cur_state.lock_state) begin
            if (sp) begin
               nxt_state.power_state = ~cur_state.power_state;
               if (!cur_state.power_state) begin
                  // turning on
                  beep = BEEP_OPEN;
                  if (req_data.filter_due) begin
                     nxt_state.fan_level = LEVEL_OFF;
                  end else if (cur_state.timer_level == LEVEL_OFF) begin
                     nxt_state.fan_level = LEVEL_LOW;
                  end else begin
                     nxt_state.timer_level = LEVEL_OFF;
                  end
               end else begin
                  // turning off, keep levels for restore
                  beep                  = BEEP_CLOSE;
                  nxt_state.saved_fan   = cur_state.fan_level;
                  nxt_state.saved_timer = cur_state.timer_level;
                  nxt_state.fan_level   = LEVEL_OFF;
                  nxt_state.timer_level = LEVEL_OFF;
               end
            end else if (h3) begin
               if (req_data.remote_ok) begin
                  rclr = 1'b1;
               end
               if ((req_data.remote_ok && cur_state.power_state) ||
                   (!req_data.remote_ok && !cur_state.power_state)) begin
                  beep                   = BEEP_SHORT;
                  nxt_state.power_state  = 1'b1;
                  nxt_state.fan_level    = cur_state.saved_fan;
                  nxt_state.timer_level  = cur_state.saved_timer;
                  nxt_state.display_mark = 1'b1;
               end
            end
         end else if (req_data.filter_due) begin
            // apart from the power key, only the filter reset is served while service is due
            if (req_data.key_code == KEY_FILTER && !cur_state.lock_state &&
                req_data.reset_armed) begin
               if (sp) begin
                  nxt_state.reset_pending = 1'b1;
               end else if (h5) begin
                  beep                    = BEEP_SHORT;
                  nxt_state.reset_pending = 1'b0;
                  fclr                    = 1'b1;
                  cclr                    = 1'b1;
               end
            end
         end else if (req_data.key_code == KEY_LOCK) begin
            if (cur_state.lock_state) begin
               if (sp) begin
                  nxt_state.lock_pending = 1'b1;
               end
               if (h3) begin
                  beep                   = BEEP_SHORT;
                  nxt_state.lock_pending = 1'b0;
                  nxt_state.lock_state   = 1'b0;
               end
            end else if (cur_state.power_state || cur_state.timer_level != LEVEL_OFF) begin
               if (sp) begin
                  nxt_state.lock_pending = 1'b1;
               end else if (h3) begin
                  beep                   = BEEP_SHORT;
                  nxt_state.lock_pending = 1'b0;
                  nxt_state.lock_state   = 1'b1;
               end
            end
         end else if (!cur_state.lock_state && req_data.key_code == KEY_TIMER) begin
            if (sp) begin
               lvl_inc = cur_state.timer_level + 3'd1;
               nxt_state.timer_level = (lvl_inc >= LEVEL_WRAP) ? LEVEL_OFF : lvl_inc;
               beep = BEEP_SHORT;
            end
         end else if (!cur_state.lock_state && req_data.key_code == KEY_FAN) begin
            if (sp && (cur_state.power_state || cur_state.timer_level != LEVEL_OFF)) begin
               lvl_inc = cur_state.fan_level + 3'd1;
               nxt_state.fan_level = (lvl_inc == LEVEL_WRAP) ? LEVEL_LOW : lvl_inc;
               beep = BEEP_SHORT;
            end
         end else if (!cur_state.lock_state && req_data.key_code == KEY_TEST) begin
            if (h3 && cur_state.power_state) begin
               beep                = BEEP_SHORT;
               nxt_state.test_mode = ~cur_state.test_mode;
               cclr                = 1'b1;
            end
         end
      end
   end

   // result beat mirrors the updated state
   always_comb begin
      rsp_data.power_ind         = nxt_state.power_state;
      rsp_data.fan_led           = nxt_state.fan_level;
      rsp_data.timer_led         = nxt_state.timer_level;
      rsp_data.lock_ind          = nxt_state.lock_state;
      rsp_data.display_off       = nxt_state.display_mark;
      rsp_data.test_mode_out     = nxt_state.test_mode;
      rsp_data.beep              = beep;
      rsp_data.filter_clear      = fclr;
      rsp_data.remote_clear      = rclr;
      rsp_data.counters_clear    = cclr;
      rsp_data.lock_pending_out  = nxt_state.lock_pending;
      rsp_data.reset_pending_out = nxt_state.reset_pending;
   end

endmodule

>>> src/appliance_key_panel_fsm_top.sv
`timescale 1ns / 1ps
// a result beat is valid in the cycle after its key beat is accepted
// throughput: one key beat per cycle while results are taken; the single result register frees as it is taken
// the next-state logic is one combinational pass between state and result registers
// reset (synchronous, active high) clears all levels, marks, saved levels and
// the result valid flag

`include "appliance_key_panel_fsm_top_assert.svh"

module appliance_key_panel_fsm_top (
   input logic      clock,
   input logic      reset,
   akp_req_if.sink   req_ch,
   akp_rsp_if.source rsp_ch
);
   import akp_pkg::*;

   akp_state_type state_ff;
   akp_state_type state_in;
   akp_rsp_type   rsp_data_ff;
   akp_rsp_type   rsp_data_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          req_fire;
   logic          rsp_mirror_ok;

   // accept while the result register is empty or being drained
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   akp_step u_step (
      .cur_state (state_ff),
      .req_data  (req_ch.data),
      .nxt_state (state_in),
      .rsp_data  (rsp_data_in)
   );

   // panel state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // result register agrees with the state it mirrors
   assign rsp_mirror_ok = (rsp_data_ff.fan_led == state_ff.fan_level) &&
                          (rsp_data_ff.timer_led == state_ff.timer_level) &&
                          (rsp_data_ff.power_ind == state_ff.power_state);

   // checks
   `AKP_ASSERT_NEXT(a_fire_gives_beat, clock, reset, req_fire, rsp_ch.valid)
   `AKP_ASSERT_NEXT(a_beat_mirrors_state, clock, reset, req_fire, rsp_mirror_ok)
   `AKP_ASSERT_ALWAYS(a_fan_range, clock, reset, state_ff.fan_level <= LEVEL_MAX)
   `AKP_ASSERT_ALWAYS(a_saved_fan_range, clock, reset, state_ff.saved_fan <= LEVEL_MAX)
   `AKP_ASSERT_ALWAYS(a_timer_range, clock, reset, state_ff.timer_level <= LEVEL_MAX)
   `AKP_ASSERT_ALWAYS(a_saved_timer_range, clock, reset, state_ff.saved_timer <= LEVEL_MAX)

endmodule

>>> dv/appliance_key_panel_fsm_top_tb.sv
`timescale 1ns / 1ps

module appliance_key_panel_fsm_top_tb;
   import akp_pkg::*;

   // receiver stall styles
   typedef enum int unsigned {
      RCV_ALWAYS,
      RCV_COIN,
      RCV_PATTERN,
      RCV_MOSTLY
   } rcv_mode_type;

   localparam int unsigned IDLE_LIMIT    = 2000;
   localparam int unsigned HOLD_OFF_LEN  = 400;
   localparam logic [15:0] STALL_PATTERN = 16'b1011_0110_1110_0101;

   logic clock;
   logic reset;

   akp_req_if req_ch ();
   akp_rsp_if rsp_ch ();

   appliance_key_panel_fsm_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // panel state as predicted from the accepted key beats
   akp_state_type panel_state;
   akp_rsp_type   expected_panel_q[$];

   int unsigned fail_count;
   int unsigned keys_sent;
   int unsigned burst_left;
   bit          no_gaps;
   bit          hold_request;
   int unsigned idle_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------

   // power back on with the saved levels
   function automatic akp_state_type restore_levels(input akp_state_type s);
      akp_state_type r;
      r              = s;
      r.power_state  = 1'b1;
      r.fan_level    = s.saved_fan;
      r.timer_level  = s.saved_timer;
      r.display_mark = 1'b1;
      return r;
   endfunction

   // apply one key beat to the panel state, return the result beat
   function automatic akp_rsp_type step_panel(input akp_req_type k);
      akp_state_type s;
      akp_rsp_type   r;
      logic [2:0]    nxt;
      s = panel_state;
      r = '0;
      r.beep = BEEP_NONE;
      if (k.short_press || k.hold_3s || k.hold_5s) begin
         if (k.key_code == KEY_POWER && !s.lock_state) begin
            if (k.short_press) begin
               s.power_state = ~s.power_state;
               if (s.power_state) begin
                  r.beep = BEEP_OPEN;
                  if (k.filter_due) s.fan_level = LEVEL_OFF;
                  else if (s.timer_level == LEVEL_OFF) s.fan_level = LEVEL_LOW;
                  else s.timer_level = LEVEL_OFF;
               end else begin
                  r.beep        = BEEP_CLOSE;
                  s.saved_fan   = s.fan_level;
                  s.saved_timer = s.timer_level;
                  s.fan_level   = LEVEL_OFF;
                  s.timer_level = LEVEL_OFF;
               end
            end else if (k.hold_3s) begin
               if (k.remote_ok) begin
                  r.remote_clear = 1'b1;
                  if (s.power_state) begin
                     r.beep = BEEP_SHORT;
                     s      = restore_levels(s);
                  end
               end else if (!s.power_state) begin
                  r.beep = BEEP_SHORT;
                  s      = restore_levels(s);
               end
            end
         end else if (k.filter_due) begin
            // apart from the power key, only an armed filter reset gets through while service is due
            if (k.key_code == KEY_FILTER && !s.lock_state && k.reset_armed) begin
               if (k.short_press) begin
                  s.reset_pending = 1'b1;
               end else if (k.hold_5s) begin
                  r.beep           = BEEP_SHORT;
                  s.reset_pending  = 1'b0;
                  r.filter_clear   = 1'b1;
                  r.counters_clear = 1'b1;
               end
            end
         end else if (k.key_code == KEY_LOCK) begin
            if (s.lock_state) begin
               if (k.short_press) s.lock_pending = 1'b1;
               if (k.hold_3s) begin
                  r.beep         = BEEP_SHORT;
                  s.lock_pending = 1'b0;
                  s.lock_state   = 1'b0;
               end
            end else if (s.power_state || s.timer_level != LEVEL_OFF) begin
               if (k.short_press) begin
                  s.lock_pending = 1'b1;
               end else if (k.hold_3s) begin
                  r.beep         = BEEP_SHORT;
                  s.lock_pending = 1'b0;
                  s.lock_state   = 1'b1;
               end
            end
         end else if (!s.lock_state && k.key_code == KEY_TIMER) begin
            if (k.short_press) begin
               nxt = s.timer_level + 3'd1;
               if (nxt >= LEVEL_WRAP) nxt = LEVEL_OFF;
               s.timer_level = nxt;
               r.beep        = BEEP_SHORT;
            end
         end else if (!s.lock_state && k.key_code == KEY_FAN) begin
            if (k.short_press && (s.power_state || s.timer_level != LEVEL_OFF)) begin
               nxt = s.fan_level + 3'd1;
               if (nxt == LEVEL_WRAP) nxt = LEVEL_LOW;
               s.fan_level = nxt;
               r.beep      = BEEP_SHORT;
            end
         end else if (!s.lock_state && k.key_code == KEY_TEST) begin
            if (k.hold_3s && s.power_state) begin
               r.beep           = BEEP_SHORT;
               s.test_mode      = ~s.test_mode;
               r.counters_clear = 1'b1;
            end
         end
      end
      // mirrors of the updated state
      r.power_ind         = s.power_state;
      r.fan_led           = s.fan_level;
      r.timer_led         = s.timer_level;
      r.lock_ind          = s.lock_state;
      r.display_off       = s.display_mark;
      r.test_mode_out     = s.test_mode;
      r.lock_pending_out  = s.lock_pending;
      r.reset_pending_out = s.reset_pending;
      panel_state = s;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      fail_count++;
      if (fail_count <= 40)
         $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
   endtask

   task automatic compare_panel(input akp_rsp_type got, input akp_rsp_type want);
      if (got.power_ind !== want.power_ind)
         report_mismatch("power_ind", got.power_ind, want.power_ind);
      if (got.fan_led !== want.fan_led)
         report_mismatch("fan_led", got.fan_led, want.fan_led);
      if (got.timer_led !== want.timer_led)
         report_mismatch("timer_led", got.timer_led, want.timer_led);
      if (got.lock_ind !== want.lock_ind)
         report_mismatch("lock_ind", got.lock_ind, want.lock_ind);
      if (got.display_off !== want.display_off)
         report_mismatch("display_off", got.display_off, want.display_off);
      if (got.test_mode_out !== want.test_mode_out)
         report_mismatch("test_mode_out", got.test_mode_out, want.test_mode_out);
      if (got.beep !== want.beep)
         report_mismatch("beep", got.beep, want.beep);
      if (got.filter_clear !== want.filter_clear)
         report_mismatch("filter_clear", got.filter_clear, want.filter_clear);
      if (got.remote_clear !== want.remote_clear)
         report_mismatch("remote_clear", got.remote_clear, want.remote_clear);
      if (got.counters_clear !== want.counters_clear)
         report_mismatch("counters_clear", got.counters_clear, want.counters_clear);
      if (got.lock_pending_out !== want.lock_pending_out)
         report_mismatch("lock_pending_out", got.lock_pending_out, want.lock_pending_out);
      if (got.reset_pending_out !== want.reset_pending_out)
         report_mismatch("reset_pending_out", got.reset_pending_out,
                         want.reset_pending_out);
   endtask

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin : result_check
      akp_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_panel_q.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            want = expected_panel_q.pop_front();
            compare_panel(rsp_ch.data, want);
         end
      end
   end

   // stop when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // receiver
   // ---------------------------------------------------------------------------

   // stall style changes on its own, long hold-off on request
   initial begin
      rcv_mode_type rcv_mode;
      int unsigned  mode_left;
      int unsigned  hold_left;
      logic [3:0]   pattern_pos;
      logic         rdy;
      rcv_mode    = RCV_ALWAYS;
      mode_left   = 0;
      hold_left   = 0;
      pattern_pos = '0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_OFF_LEN;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            rcv_mode  = rcv_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         pattern_pos++;
         if (hold_left != 0) begin
            hold_left--;
            rdy = 1'b0;
         end else begin
            case (rcv_mode)
               RCV_ALWAYS:  rdy = 1'b1;
               RCV_COIN:    rdy = 1'($urandom_range(0, 1));
               RCV_PATTERN: rdy = STALL_PATTERN[pattern_pos];
               default:     rdy = ($urandom_range(0, 9) != 0);
            endcase
         end
         rsp_ch.ready <= rdy;
      end
   end

   // ---------------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------------

   function automatic akp_req_type key_event(input logic [2:0] code, input logic sp,
                                             input logic h3, input logic h5,
                                             input logic due, input logic rok,
                                             input logic armed);
      akp_req_type k;
      k.key_code    = code;
      k.short_press = sp;
      k.hold_3s     = h3;
      k.hold_5s     = h5;
      k.filter_due  = due;
      k.remote_ok   = rok;
      k.reset_armed = armed;
      return k;
   endfunction

   // offer one key beat, in bursts with random gaps between them
   task automatic send_key(input akp_req_type k);
      int unsigned gap;
      if (burst_left == 0 && !no_gaps) begin
         gap = $urandom_range(1, 8);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= k;
      do @(posedge clock); while (!req_ch.ready);
      expected_panel_q.push_back(step_panel(k));
      keys_sent++;
      if (burst_left != 0) burst_left--;
   endtask

   // sender idles until every predicted result has come back
   task automatic wait_all_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_panel_q.size() != 0);
   endtask

   // mostly plain single presses, some combined flags and unused codes
   function automatic akp_req_type random_key();
      akp_req_type k;
      int unsigned f;
      k.key_code = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(1, 6));
      f = $urandom_range(0, 99);
      {k.short_press, k.hold_3s, k.hold_5s} = (f < 55) ? 3'b100 :
                                              (f < 80) ? 3'b010 :
                                              (f < 90) ? 3'b001 :
                                              (f < 94) ? 3'b000 : 3'($urandom_range(0, 7));
      k.filter_due  = ($urandom_range(0, 9) == 0);
      k.remote_ok   = ($urandom_range(0, 2) == 0);
      k.reset_armed = 1'($urandom_range(0, 1));
      return k;
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // power on, fan and timer wrap, save and restore
   task automatic test_power_and_levels();
      send_key(key_event(KEY_POWER, 1, 0, 0, 0, 0, 0));
      repeat (4) send_key(key_event(KEY_FAN, 1, 0, 0, 0, 0, 0));
      repeat (5) send_key(key_event(KEY_TIMER, 1, 0, 0, 0, 0, 0));
      send_key(key_event(KEY_POWER, 1, 0, 0, 0, 0, 0));
      send_key(key_event(KEY_POWER, 0, 1, 0, 0, 0, 0));
      send_key(key_event(KEY_POWER, 0, 1, 0, 0, 1, 0));
      // short press wins over the hold on the power key
      send_key(key_event(KEY_POWER, 1, 1, 0, 0, 1, 1));
      // remote confirm while off only clears the flag
      send_key(key_event(KEY_POWER, 0, 1, 0, 0, 1, 0));
   endtask

   // lock refused while off, then set, blocking, cleared by press plus hold
   task automatic test_child_lock();
      send_key(key_event(KEY_LOCK, 0, 1, 0, 0, 0, 0));
      send_key(key_event(KEY_POWER, 1, 0, 0, 0, 0, 0));
      send_key(key_event(KEY_LOCK, 1, 0, 0, 0, 0, 0));
      send_key(key_event(KEY_LOCK, 0, 1, 0, 0, 0, 0));
      send_key(key_event(KEY_FAN, 1, 0, 0, 0, 0, 0));
      send_key(key_event(KEY_LOCK, 1, 1, 0, 0, 0, 0));
   endtask

   // filter service due: only the armed reset key and the power key act
   task automatic test_filter_service();
      send_key(key_event(KEY_FILTER, 1, 0, 0, 1, 0, 1));
      send_key(key_event(KEY_TIMER, 1, 0, 0, 1, 0, 1));
      send_key(key_event(KEY_FILTER, 0, 0, 1, 1, 1, 1));
      send_key(key_event(KEY_POWER, 1, 0, 0, 1, 0, 0));
      send_key(key_event(KEY_POWER, 1, 0, 0, 1, 0, 0));
   endtask

   // unused codes, no press flag, test mode toggle
   task automatic test_unused_and_combined();
      send_key(key_event(3'd0, 1, 1, 1, 0, 1, 1));
      send_key(key_event(3'd7, 1, 1, 1, 1, 1, 1));
      send_key(key_event(KEY_TEST, 0, 1, 0, 0, 0, 0));
      send_key(key_event(KEY_POWER, 0, 0, 0, 1, 1, 1));
   endtask

   // well-formed press sequences with random content, plus noise
   task automatic test_random_keys(input int unsigned count);
      int unsigned target;
      int unsigned sel;
      target = keys_sent + count;
      while (keys_sent < target) begin
         sel = $urandom_range(0, 9);
         case (sel)
            5: begin
               send_key(key_event(KEY_LOCK, 1, 0, 0, 0, 1'($urandom), 1'($urandom)));
               send_key(key_event(KEY_LOCK, 0, 1, 0, 0, 1'($urandom), 1'($urandom)));
            end
            6: begin
               send_key(key_event(KEY_FILTER, 1, 0, 0, 1, 1'($urandom), 1));
               send_key(key_event(KEY_FILTER, 0, 0, 1, 1, 1'($urandom),
                                  ($urandom_range(0, 3) != 0)));
            end
            7: begin
               send_key(key_event(KEY_POWER, 1, 0, 0, 0, 0, 1'($urandom)));
               repeat ($urandom_range(1, 4))
                  send_key(key_event(($urandom_range(0, 1) != 0) ? KEY_FAN : KEY_TIMER,
                                     1, 0, 0, 0, 0, 0));
            end
            8: begin
               send_key(key_event(KEY_POWER, 1, 0, 0, 0, 0, 0));
               send_key(key_event(KEY_POWER, 0, 1, 0, 0, 1'($urandom), 0));
            end
            9: begin
               if ($urandom_range(0, 1) != 0)
                  send_key(key_event(KEY_TEST, 0, 1, 0, 0, 0, 0));
               else
                  send_key(akp_req_type'(9'($urandom)));
            end
            default: send_key(random_key());
         endcase
      end
   endtask

   // receiver holds off while the sender keeps offering beats
   task automatic test_receiver_hold_off();
      no_gaps      = 1'b1;
      hold_request = 1'b1;
      repeat (40) send_key(random_key());
      no_gaps = 1'b0;
      wait_all_results();
   endtask

   // ---------------------------------------------------------------------------
   // sequence of tests
   // ---------------------------------------------------------------------------

   initial begin
      panel_state  = '0;
      fail_count   = 0;
      keys_sent    = 0;
      burst_left   = 0;
      no_gaps      = 1'b0;
      hold_request = 1'b0;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_power_and_levels();
      test_child_lock();
      test_filter_service();
      test_unused_and_combined();
      wait_all_results();
      test_random_keys(950);
      test_receiver_hold_off();
      test_random_keys(950);
      wait_all_results();

      // settle, then verdict
      repeat (4) @(posedge clock);
      if (expected_panel_q.size() != 0)
         report_mismatch("results still outstanding", expected_panel_q.size(), 0);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
